// ----- src/nearest_palette_color_mapper_assert.svh -----
// Assertion helpers for the palette mapper. They sample on aclk and are
// disabled while aresetn is low. Both expand to nothing in synthesis.
`ifndef NEAREST_PALETTE_COLOR_MAPPER_ASSERT_SVH
`define NEAREST_PALETTE_COLOR_MAPPER_ASSERT_SVH

`ifndef SYNTHESIS

// expr must hold at every sampled edge
`define NPCM_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error("npcm: invariant violated");

// cons must hold in the cycle after ante
`define NPCM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("npcm: sequence violated");

`else

`define NPCM_ASSERT_ALWAYS(label, expr)
`define NPCM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/npcm_pkg.sv -----
`timescale 1ns / 1ps

package npcm_pkg;

    localparam int COMP_W  = 8;   // color component width
    localparam int IDX_W   = 8;   // entry index width on the ports
    localparam int DIST_W  = 11;  // six terms of up to 255 each
    localparam int DEPTH_W = 4;
    localparam int SIZE_W  = 9;

    localparam logic REG_LOGICAL_DEPTH = 1'b0;
    localparam logic REG_PALETTE_SIZE  = 1'b1;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = 4'd8;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 9'd1;

    // One item travelling down the cell chain: either a palette load or a
    // pixel carrying its best match so far.
    typedef struct packed {
        logic              valid;
        logic              is_pixel;
        logic [IDX_W-1:0]  entry_index;
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic [DIST_W-1:0] lead_score;
        logic [IDX_W-1:0]  lead_slot;
    } item_t;

endpackage

// ----- src/nearest_palette_color_mapper.sv -----
`timescale 1ns / 1ps

// Channel   Dir  Ports                        Contents
// s_*       in   tvalid/tready/tdata/tuser    load or pixel
// m_*       out  tvalid/tready/tdata          palette_index
// APB       in   psel/penable/pwrite/paddr    logical_depth @0, palette_size @4
//
// One item enters per cycle while no result is held; a result passes through the
// cells in order: the transfer loads the first cell, then the remaining
// PALETTE_DEPTH - 1 cells and the output register follow.
// The whole chain moves as one: a held result stalls every cell and s_tready.
// Reset clears the item valid bits and the registers; palette entries are not
// cleared and must be loaded before they fall inside palette_size.
module nearest_palette_color_mapper #(
    parameter int PALETTE_DEPTH = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // entry_index[7:0], red[15:8], green[23:16], blue[31:24]
    input  logic [0:0]  s_tuser,   // command[0]: 0 load, 1 pixel

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // palette_index[7:0]

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [npcm_pkg::DEPTH_W-1:0] depth_reg;
    logic [npcm_pkg::SIZE_W-1:0]  size_reg;
    logic [npcm_pkg::DEPTH_W-1:0] depth_eff;
    logic [npcm_pkg::SIZE_W-1:0]  size_eff;
    logic [2:0]                   shift;
    logic                         cfg_wr;

    npcm_pkg::item_t             chain [0:PALETTE_DEPTH];
    logic                        advance;
    logic                        out_valid_reg;
    logic [npcm_pkg::IDX_W-1:0]  out_idx_reg;
    logic                        load_leaving;

    // ---------------- configuration ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg <= npcm_pkg::DEPTH_RESET;
            size_reg  <= npcm_pkg::SIZE_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                npcm_pkg::REG_LOGICAL_DEPTH: depth_reg <= pwdata[npcm_pkg::DEPTH_W-1:0];
                npcm_pkg::REG_PALETTE_SIZE:  size_reg  <= pwdata[npcm_pkg::SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            npcm_pkg::REG_LOGICAL_DEPTH: prdata = 32'(depth_reg);
            npcm_pkg::REG_PALETTE_SIZE:  prdata = 32'(size_reg);
            default:                     prdata = '0;
        endcase
    end

    always_comb begin
        if (depth_reg == '0)
            depth_eff = 4'd1;
        else if (depth_reg > 4'd8)
            depth_eff = 4'd8;
        else
            depth_eff = depth_reg;
        shift = 3'(4'd8 - depth_eff);

        if (size_reg == '0)
            size_eff = 9'd1;
        else if (size_reg > npcm_pkg::SIZE_W'(PALETTE_DEPTH))
            size_eff = npcm_pkg::SIZE_W'(PALETTE_DEPTH);
        else
            size_eff = size_reg;
    end

    // ---------------- chain entry ----------------
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = advance;

    always_comb begin
        chain[0]             = '0;
        chain[0].valid       = s_tvalid;
        chain[0].is_pixel    = s_tuser[0];
        chain[0].entry_index = s_tdata[7:0];
        // pixels are reduced to the logical depth, loads are stored as given
        if (s_tuser[0]) begin
            chain[0].red   = s_tdata[15:8]  >> shift;
            chain[0].green = s_tdata[23:16] >> shift;
            chain[0].blue  = s_tdata[31:24] >> shift;
        end else begin
            chain[0].red   = s_tdata[15:8];
            chain[0].green = s_tdata[23:16];
            chain[0].blue  = s_tdata[31:24];
        end
    end

    for (genvar k = 0; k < PALETTE_DEPTH; k++) begin : g_cell
        npcm_cell #(
            .K(k)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .advance  (advance),
            .size_eff (size_eff),
            .item_in  (chain[k]),
            .item_out (chain[k+1])
        );
    end

    // ---------------- output register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= chain[PALETTE_DEPTH].valid && chain[PALETTE_DEPTH].is_pixel;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_idx_reg <= chain[PALETTE_DEPTH].lead_slot;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_idx_reg;

    // ---------------- checks ----------------
    assign load_leaving = advance && chain[PALETTE_DEPTH].valid
                       && !chain[PALETTE_DEPTH].is_pixel;

`include "nearest_palette_color_mapper_assert.svh"

    `NPCM_ASSERT_ALWAYS(a_stall_freezes_input, !(m_tvalid && !m_tready) || !s_tready)
    `NPCM_ASSERT_ALWAYS(a_index_in_range, !m_tvalid || ({1'b0, m_tdata} < size_eff))
    `NPCM_ASSERT_NEXT(a_load_gives_no_result, load_leaving, !m_tvalid)

endmodule

// ----- src/npcm_cell.sv -----
`timescale 1ns / 1ps

// One palette entry. Loads addressed to this slot are captured as they pass;
// pixels compare against the stored color and keep the better candidate.
module npcm_cell #(
    parameter int K = 0
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         advance,
    input  logic [npcm_pkg::SIZE_W-1:0]  size_eff,
    input  npcm_pkg::item_t              item_in,
    output npcm_pkg::item_t              item_out
);

    logic [npcm_pkg::COMP_W-1:0] ent_r_reg, ent_g_reg, ent_b_reg;
    npcm_pkg::item_t             item_reg, item_next;

    logic [npcm_pkg::COMP_W-1:0] dr, dg, db, drg, drb, dgb;
    logic [npcm_pkg::DIST_W-1:0] score;
    logic                        active, take, load_hit;

    function automatic logic [npcm_pkg::COMP_W-1:0] absdiff(
        input logic [npcm_pkg::COMP_W-1:0] x,
        input logic [npcm_pkg::COMP_W-1:0] y
    );
        return (x > y) ? (x - y) : (y - x);
    endfunction

    always_comb begin
        dr    = absdiff(item_in.red,   ent_r_reg);
        dg    = absdiff(item_in.green, ent_g_reg);
        db    = absdiff(item_in.blue,  ent_b_reg);
        drg   = absdiff(dr, dg);
        drb   = absdiff(dr, db);
        dgb   = absdiff(dg, db);
        score = npcm_pkg::DIST_W'(dr) + npcm_pkg::DIST_W'(dg) + npcm_pkg::DIST_W'(db)
              + npcm_pkg::DIST_W'(drg) + npcm_pkg::DIST_W'(drb) + npcm_pkg::DIST_W'(dgb);

        active   = npcm_pkg::SIZE_W'(K) < size_eff;
        // slot 0 always seeds the search; later slots must lie inside palette_size and be strictly closer
        take     = item_in.is_pixel && ((K == 0) || (active && (score < item_in.lead_score)));
        load_hit = item_in.valid && !item_in.is_pixel
                && (item_in.entry_index == npcm_pkg::IDX_W'(K));

        item_next = item_in;
        if (take) begin
            item_next.lead_score = score;
            item_next.lead_slot  = npcm_pkg::IDX_W'(K);
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && load_hit) begin
            ent_r_reg <= item_in.red;
            ent_g_reg <= item_in.green;
            ent_b_reg <= item_in.blue;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_reg <= '0;
        end else if (advance) begin
            item_reg <= item_next;
        end
    end

    assign item_out = item_reg;

endmodule

// ----- test/nearest_palette_color_mapper_test.sv -----
`timescale 1ns / 1ps

module nearest_palette_color_mapper_test;
    import npcm_pkg::*;

    localparam int PAL_DEPTH      = 256;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES  = PAL_DEPTH + 16;  // chain length plus output register, with margin
    localparam int PHASE_ITEMS    = 75;
    localparam int NUM_PHASES     = 8;
    localparam int PLAN_ROWS      = 25;

    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    typedef enum logic [1:0] {ROW_LOAD, ROW_PIXEL, ROW_WRITE_REG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic              reg_sel;      // only used by register writes
        logic [8:0]        arg;          // entry index, or register value
        logic [COMP_W-1:0] red;
        logic [COMP_W-1:0] green;
        logic [COMP_W-1:0] blue;
        logic              typed;        // expected index given in the row
        logic [IDX_W-1:0]  typed_index;
    } plan_row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    nearest_palette_color_mapper #(
        .PALETTE_DEPTH(PAL_DEPTH)
    ) DUT (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 aclk = ~aclk;

    // palette mirror and register copies
    logic [COMP_W-1:0]  entry_red   [PAL_DEPTH];
    logic [COMP_W-1:0]  entry_green [PAL_DEPTH];
    logic [COMP_W-1:0]  entry_blue  [PAL_DEPTH];
    bit                 loaded      [PAL_DEPTH];
    logic [DEPTH_W-1:0] depth_reg = DEPTH_RESET;
    logic [SIZE_W-1:0]  size_reg  = SIZE_RESET;

    logic [IDX_W-1:0] expected_index_q [$];
    logic [IDX_W-1:0] oldest_index;

    int send_idle_pct  = 0;
    int recv_idle_pct  = 0;
    int pixel_count    = 0;
    int load_count     = 0;
    int checked_count  = 0;
    int mismatch_count = 0;
    int quiet_cycles   = 0;

    plan_row_t plan [PLAN_ROWS];

    function automatic int comp_gap(int x, int y);
        return x > y ? x - y : y - x;
    endfunction

    function automatic int kept_depth();
        if (depth_reg < 1) return 1;
        if (depth_reg > COMP_W) return COMP_W;
        return int'(depth_reg);
    endfunction

    function automatic int searched_entries();
        if (size_reg < 1) return 1;
        if (size_reg > PAL_DEPTH) return PAL_DEPTH;
        return int'(size_reg);
    endfunction

    function automatic logic [IDX_W-1:0] nearest_entry(logic [COMP_W-1:0] r,
                                                       logic [COMP_W-1:0] g,
                                                       logic [COMP_W-1:0] b);
        int shift, dr, dg, db, score, lead_score;
        logic [IDX_W-1:0] best;
        shift = COMP_W - kept_depth();
        r = r >> shift;
        g = g >> shift;
        b = b >> shift;
        best = '0;
        lead_score = 0;
        for (int k = 0; k < searched_entries(); k++) begin
            dr = comp_gap(int'(r), int'(entry_red[k]));
            dg = comp_gap(int'(g), int'(entry_green[k]));
            db = comp_gap(int'(b), int'(entry_blue[k]));
            score = dr + dg + db + comp_gap(dr, dg) + comp_gap(dr, db) + comp_gap(dg, db);
            // strict compare keeps the lowest index on a tie
            if (k == 0 || score < lead_score) begin
                lead_score = score;
                best = k[IDX_W-1:0];
            end
        end
        return best;
    endfunction

    function automatic logic [COMP_W-1:0] load_component(int mask);
        if ($urandom_range(4) == 0) return COMP_W'($urandom_range(255));
        return COMP_W'($urandom & mask);
    endfunction

    // pixel byte that lands on or next to a stored component after the shift
    function automatic logic [COMP_W-1:0] near_component(logic [COMP_W-1:0] e, int shift);
        logic [COMP_W-1:0] v;
        v = COMP_W'((e << shift) | ($urandom & ((1 << shift) - 1)));
        if ($urandom_range(3) == 0)
            v = COMP_W'(v + ($urandom_range(2) << shift) - (1 << shift));
        return v;
    endfunction

    task automatic note_mismatch(input string what, input logic [IDX_W-1:0] want,
                                 input logic [IDX_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch (%s): palette_index expected %0d, got %0d", what, want, got);
    endtask

    // called just after a falling edge; returns just after the falling edge that follows its transfer
    task automatic send_item(input logic cmd, input logic [7:0] slot,
                             input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                             input logic typed, input logic [IDX_W-1:0] typed_index);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = cmd;
        s_tdata  = {b, g, r, slot};
        do @(posedge aclk); while (!s_tready);
        if (cmd == CMD_LOAD) begin
            entry_red[slot]   = r;
            entry_green[slot] = g;
            entry_blue[slot]  = b;
            loaded[slot]      = 1'b1;
            load_count++;
        end else begin
            expected_index_q.push_back(typed ? typed_index : nearest_entry(r, g, b));
            pixel_count++;
        end
        @(negedge aclk);
    endtask

    // settle covers loads still travelling down the chain
    task automatic wait_drained(input bit settle);
        s_tvalid = 1'b0;
        while (expected_index_q.size() != 0) @(negedge aclk);
        if (settle) repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(input logic sel, input logic [31:0] value);
        wait_drained(1'b1);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {sel, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (sel == REG_LOGICAL_DEPTH)
            depth_reg = value[DEPTH_W-1:0];
        else
            size_reg = value[SIZE_W-1:0];
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // every searched entry must hold a load before a pixel can reach it
    task automatic fill_palette();
        int mask;
        mask = (1 << kept_depth()) - 1;
        for (int k = 0; k < searched_entries(); k++)
            if (!loaded[k])
                send_item(CMD_LOAD, k[7:0], load_component(mask), load_component(mask),
                          load_component(mask), 1'b0, '0);
    endtask

    always @(negedge aclk) m_tready <= ($urandom_range(99) >= recv_idle_pct);

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_index_q.size() == 0) begin
                note_mismatch("no pixel pending", 'x, m_tdata);
            end else begin
                oldest_index = expected_index_q.pop_front();
                checked_count++;
                if (m_tdata !== oldest_index) note_mismatch("wrong index", oldest_index, m_tdata);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: %0d cycles without a transfer, %0d results outstanding",
                     quiet_cycles, expected_index_q.size());
            $display("nearest_palette_color_mapper_test: FAIL");
            $finish;
        end
    end

    initial begin
        int depth_plan [NUM_PHASES];
        int size_plan  [NUM_PHASES];
        int shift, mask, k, dv, sv;
        logic [7:0] slot;

        depth_plan = '{8, 1, 15, 4, 0, 0, 0, 2};
        size_plan  = '{256, 2, 511, 16, 0, 0, 0, 200};

        // reset state: depth 8, one entry searched
        plan = '{
            '{ROW_LOAD,      REG_LOGICAL_DEPTH, 9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd0},
            '{ROW_WRITE_REG, REG_PALETTE_SIZE,  9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd128, 8'd1,   8'd254, 1'b1, 8'd0},
            '{ROW_LOAD,      REG_LOGICAL_DEPTH, 9'd1,   8'd255, 8'd255, 8'd255, 1'b0, 8'd0},
            '{ROW_LOAD,      REG_LOGICAL_DEPTH, 9'd2,   8'd10,  8'd200, 8'd30,  1'b0, 8'd0},
            '{ROW_LOAD,      REG_LOGICAL_DEPTH, 9'd3,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
            '{ROW_WRITE_REG, REG_PALETTE_SIZE,  9'd4,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd1},
            // entries 0 and 3 tie, lower one wins
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd10,  8'd200, 8'd30,  1'b1, 8'd2},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd20,  8'd190, 8'd40,  1'b0, 8'd0},
            '{ROW_WRITE_REG, REG_LOGICAL_DEPTH, 9'd1,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd255, 8'd0,   8'd255, 1'b0, 8'd0},
            '{ROW_LOAD,      REG_LOGICAL_DEPTH, 9'd3,   8'd1,   8'd1,   8'd1,   1'b0, 8'd0},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd200, 8'd130, 8'd255, 1'b1, 8'd3},
            // stored as given, past the one-bit range
            '{ROW_LOAD,      REG_LOGICAL_DEPTH, 9'd2,   8'd200, 8'd3,   8'd7,   1'b0, 8'd0},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd0,   8'd0,   8'd0,   1'b1, 8'd0},
            '{ROW_WRITE_REG, REG_LOGICAL_DEPTH, 9'd0,   8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd3},
            '{ROW_WRITE_REG, REG_LOGICAL_DEPTH, 9'd15,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd255, 8'd255, 8'd255, 1'b1, 8'd1},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd200, 8'd3,   8'd7,   1'b1, 8'd2},
            '{ROW_PIXEL,     REG_LOGICAL_DEPTH, 9'd0,   8'd0,   8'd255, 8'd0,   1'b0, 8'd0}
        };

        repeat (4) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_WRITE_REG: write_reg(plan[i].reg_sel, {23'd0, plan[i].arg});
                ROW_LOAD:      send_item(CMD_LOAD, plan[i].arg[7:0], plan[i].red,
                                         plan[i].green, plan[i].blue, 1'b0, '0);
                default:       send_item(CMD_PIXEL, plan[i].arg[7:0], plan[i].red,
                                         plan[i].green, plan[i].blue, plan[i].typed,
                                         plan[i].typed_index);
            endcase
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
                1: begin send_idle_pct = 86; recv_idle_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_idle_pct = 86; end
                default: begin send_idle_pct = 37; recv_idle_pct = 37; end
            endcase
            dv = (p == 5 || p == 6) ? $urandom_range(8, 1) : depth_plan[p];
            sv = (p == 5 || p == 6) ? $urandom_range(PAL_DEPTH, 1) : size_plan[p];
            write_reg(REG_LOGICAL_DEPTH, dv);
            write_reg(REG_PALETTE_SIZE, sv);
            fill_palette();
            shift = COMP_W - kept_depth();
            mask  = (1 << kept_depth()) - 1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // hold off once until the chain has handed back every pixel
                if (p == 2 && n == PHASE_ITEMS / 2) wait_drained(1'b0);
                if ($urandom_range(3) == 0) begin
                    slot = ($urandom_range(99) < 70) ? 8'($urandom_range(searched_entries() - 1))
                                                     : 8'($urandom_range(255));
                    send_item(CMD_LOAD, slot, load_component(mask), load_component(mask),
                              load_component(mask), 1'b0, '0);
                end else if ($urandom_range(9) < 6) begin
                    k = $urandom_range(searched_entries() - 1);
                    send_item(CMD_PIXEL, 8'($urandom), near_component(entry_red[k], shift),
                              near_component(entry_green[k], shift),
                              near_component(entry_blue[k], shift), 1'b0, '0);
                end else begin
                    send_item(CMD_PIXEL, 8'($urandom), 8'($urandom), 8'($urandom),
                              8'($urandom), 1'b0, '0);
                end
            end
        end

        wait_drained(1'b1);
        $display("covered %0d pixel and %0d palette load transfers over %0d register phases,",
                 pixel_count, load_count, NUM_PHASES + 1);
        $display("including tie-breaks, depth and size clamping; %0d results checked",
                 checked_count);
        if (mismatch_count == 0 && expected_index_q.size() == 0)
            $display("nearest_palette_color_mapper_test: PASS");
        else
            $display("nearest_palette_color_mapper_test: FAIL");
        $finish;
    end

endmodule
